>>> design/icmp46_pkg.sv
// shared constants, codes and pointer map for the icmpv4 to icmpv6 header translator
// no dependencies; imported by icmp4_to_icmp6_header_translate and the testbench
`default_nettype none

package icmp46_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_NAT64_MODE      = 3'd0;
    localparam logic [2:0] CFG_PLATEAU_COUNT   = 3'd1;
    localparam logic [2:0] CFG_PLATEAUS_FIRST  = 3'd2;
    localparam logic [2:0] CFG_PLATEAUS_MIDDLE = 3'd3;
    localparam logic [2:0] CFG_PLATEAUS_LAST   = 3'd4;

    // icmpv4 types
    localparam logic [7:0] ICMP4_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] ICMP4_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] ICMP4_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] ICMP4_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] ICMP4_PARAM_PROBLEM = 8'd12;

    // icmpv4 destination unreachable codes
    localparam logic [7:0] UNR_NET            = 8'd0;
    localparam logic [7:0] UNR_HOST           = 8'd1;
    localparam logic [7:0] UNR_PROTO          = 8'd2;
    localparam logic [7:0] UNR_PORT           = 8'd3;
    localparam logic [7:0] UNR_FRAG_NEEDED    = 8'd4;
    localparam logic [7:0] UNR_SRC_ROUTE      = 8'd5;
    localparam logic [7:0] UNR_NET_UNKNOWN    = 8'd6;
    localparam logic [7:0] UNR_HOST_UNKNOWN   = 8'd7;
    localparam logic [7:0] UNR_HOST_ISOLATED  = 8'd8;
    localparam logic [7:0] UNR_NET_PROHIB     = 8'd9;
    localparam logic [7:0] UNR_HOST_PROHIB    = 8'd10;
    localparam logic [7:0] UNR_NET_TOS        = 8'd11;
    localparam logic [7:0] UNR_HOST_TOS       = 8'd12;
    localparam logic [7:0] UNR_ADMIN_PROHIB   = 8'd13;
    localparam logic [7:0] UNR_PREC_CUTOFF    = 8'd15;

    // icmpv4 parameter problem codes that translate
    localparam logic [7:0] PP4_POINTER        = 8'd0;
    localparam logic [7:0] PP4_BAD_LENGTH     = 8'd2;

    // icmpv6 types
    localparam logic [7:0] ICMP6_DEST_UNREACH  = 8'd1;
    localparam logic [7:0] ICMP6_PKT_TOO_BIG   = 8'd2;
    localparam logic [7:0] ICMP6_TIME_EXCEEDED = 8'd3;
    localparam logic [7:0] ICMP6_PARAM_PROBLEM = 8'd4;
    localparam logic [7:0] ICMP6_ECHO_REQUEST  = 8'd128;
    localparam logic [7:0] ICMP6_ECHO_REPLY    = 8'd129;

    // icmpv6 codes
    localparam logic [7:0] C6_ZERO            = 8'd0;
    localparam logic [7:0] C6_NO_ROUTE        = 8'd0;
    localparam logic [7:0] C6_ADMIN_PROHIB    = 8'd1;
    localparam logic [7:0] C6_PORT_UNREACH    = 8'd4;
    localparam logic [7:0] C6_ERR_HEADER      = 8'd0;
    localparam logic [7:0] C6_UNRECOG_NH      = 8'd1;

    // pointer to the ipv6 next header field
    localparam logic [31:0] PTR6_NEXT_HEADER  = 32'd6;

    localparam logic [7:0]  PTR_NONE          = 8'd255;
    localparam logic [7:0]  PTR_MAP_LEN       = 8'd20;
    localparam logic [15:0] IPV4_HDR_DELTA    = 16'd20;
    localparam logic [28:0] MIN_MTU6          = 29'd1280;
    localparam int          PLATEAU_W         = 16;
    localparam int          PLATEAU_SLOTS     = 12;

    // ipv4 header pointer to ipv6 header pointer
    function automatic logic [7:0] ptr_map(input logic [7:0] p);
        logic [7:0] m;
        case (p)
            8'd0:                    m = 8'd0;
            8'd1:                    m = 8'd1;
            8'd2, 8'd3:              m = 8'd4;
            8'd8:                    m = 8'd7;
            8'd9:                    m = 8'd6;
            8'd12, 8'd13, 8'd14, 8'd15: m = 8'd8;
            8'd16, 8'd17, 8'd18, 8'd19: m = 8'd24;
            default:                 m = PTR_NONE;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/icmp4_to_icmp6_header_translate.sv
// icmpv4 to icmpv6 header translator, four register stages
// depends on icmp46_pkg
`default_nettype none

// Translates one ICMPv4 header per request into its ICMPv6 counterpart or a
// drop verdict. Throughput is one request per clock as long as the result side
// keeps up. The four register stages (input capture, decode and plateau
// compares, plateau priority select and MTU adds, three-way minimum and 1280
// clamp) follow in that order from the accepting edge, the last being the
// result register, which feeds m_tdata. Each stage holds its own
// valid bit and advances whenever the stage after it is empty or moving, so
// backpressure on the result side fills bubbles first and never drops or
// repeats a request. Configuration writes are always ready and take effect
// at once; they must only be issued while the pipeline is empty. A drop
// verdict comes with zero type, code and rest word.
module icmp4_to_icmp6_header_translate #(
    parameter int MAX_PLATEAUS = 12
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    // input requests
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // lsb up: icmp4_type[7:0], icmp4_code[15:8], icmp4_rest[47:16],
    // inner_total_length[63:48], ipv6_link_mtu[91:64],
    // ipv4_link_mtu[119:92], nat64_icmp_id[135:120]
    input  wire logic [135:0] s_tdata,
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // lsb up: v6_type[7:0], v6_code[15:8], icmp6_rest[47:16]
    output logic [47:0]       m_tdata,
    // drop[0]
    output logic [0:0]        m_tuser
);
    import icmp46_pkg::*;

    // ---------------- configuration registers ----------------
    logic                               nat64_mode_reg;
    logic [3:0]                         plateau_count_reg;
    logic [PLATEAU_SLOTS*PLATEAU_W-1:0] plateaus_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nat64_mode_reg    <= 1'b0;
            plateau_count_reg <= 4'd0;
            plateaus_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NAT64_MODE:      nat64_mode_reg        <= cfg_data[0];
                CFG_PLATEAU_COUNT:   plateau_count_reg     <= cfg_data[3:0];
                CFG_PLATEAUS_FIRST:  plateaus_reg[63:0]    <= cfg_data;
                CFG_PLATEAUS_MIDDLE: plateaus_reg[127:64]  <= cfg_data;
                CFG_PLATEAUS_LAST:   plateaus_reg[191:128] <= cfg_data;
                default: begin
                    // writes beyond the register list are ignored
                end
            endcase
        end
    end

    // counts above the plateau table size saturate
    logic [3:0] count_eff;
    assign count_eff = (plateau_count_reg > 4'(MAX_PLATEAUS)) ? 4'(MAX_PLATEAUS)
                                                               : plateau_count_reg;

    // ---------------- stage valid bits and advance ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // a stage loads when it is empty or the stage after it takes its content
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: input capture ----------------
    logic [7:0]  type1_reg, code1_reg;
    logic [31:0] rest1_reg;
    logic [15:0] totlen1_reg, id1_reg;
    logic [27:0] mtu6_1_reg, mtu4_1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            type1_reg   <= s_tdata[7:0];
            code1_reg   <= s_tdata[15:8];
            rest1_reg   <= s_tdata[47:16];
            totlen1_reg <= s_tdata[63:48];
            mtu6_1_reg  <= s_tdata[91:64];
            mtu4_1_reg  <= s_tdata[119:92];
            id1_reg     <= s_tdata[135:120];
        end
    end

    // ---------------- stage 2: decode and plateau compares ----------------
    logic [7:0]              t6_next, c6_next;
    logic [31:0]             r6_next;
    logic                    drop_next, is_mtu_next;
    logic [MAX_PLATEAUS-1:0] hit_next;
    logic [7:0]              ptr6;

    assign ptr6 = ptr_map(rest1_reg[31:24]);

    always_comb begin
        t6_next     = 8'd0;
        c6_next     = 8'd0;
        r6_next     = 32'd0;
        drop_next   = 1'b0;
        is_mtu_next = 1'b0;
        case (type1_reg)
            ICMP4_ECHO_REQUEST, ICMP4_ECHO_REPLY: begin
                t6_next = (type1_reg == ICMP4_ECHO_REQUEST) ? ICMP6_ECHO_REQUEST
                                                            : ICMP6_ECHO_REPLY;
                c6_next = C6_ZERO;
                // nat64 swaps in the translated identifier, sequence stays
                r6_next = nat64_mode_reg ? {id1_reg, rest1_reg[15:0]} : rest1_reg;
            end
            ICMP4_DEST_UNREACH: begin
                t6_next = ICMP6_DEST_UNREACH;
                case (code1_reg)
                    UNR_NET, UNR_HOST, UNR_SRC_ROUTE, UNR_NET_UNKNOWN,
                    UNR_HOST_UNKNOWN, UNR_HOST_ISOLATED, UNR_NET_TOS,
                    UNR_HOST_TOS: begin
                        c6_next = C6_NO_ROUTE;
                    end
                    UNR_PROTO: begin
                        // protocol unreachable becomes a next header problem
                        t6_next = ICMP6_PARAM_PROBLEM;
                        c6_next = C6_UNRECOG_NH;
                        r6_next = PTR6_NEXT_HEADER;
                    end
                    UNR_PORT: begin
                        c6_next = C6_PORT_UNREACH;
                    end
                    UNR_FRAG_NEEDED: begin
                        t6_next     = ICMP6_PKT_TOO_BIG;
                        c6_next     = C6_ZERO;
                        is_mtu_next = 1'b1;
                    end
                    UNR_NET_PROHIB, UNR_HOST_PROHIB, UNR_ADMIN_PROHIB,
                    UNR_PREC_CUTOFF: begin
                        c6_next = C6_ADMIN_PROHIB;
                    end
                    default: begin
                        drop_next = 1'b1;
                    end
                endcase
            end
            ICMP4_TIME_EXCEEDED: begin
                t6_next = ICMP6_TIME_EXCEEDED;
                c6_next = code1_reg;
            end
            ICMP4_PARAM_PROBLEM: begin
                if ((code1_reg == PP4_POINTER || code1_reg == PP4_BAD_LENGTH)
                    && ptr6 != PTR_NONE) begin
                    t6_next = ICMP6_PARAM_PROBLEM;
                    c6_next = C6_ERR_HEADER;
                    r6_next = {24'd0, ptr6};
                end else begin
                    drop_next = 1'b1;
                end
            end
            default: begin
                drop_next = 1'b1;
            end
        endcase
        if (drop_next) begin
            t6_next     = 8'd0;
            c6_next     = 8'd0;
            r6_next     = 32'd0;
            is_mtu_next = 1'b0;
        end
    end

    // plateau entries below the inner length, limited to the valid count
    always_comb begin
        for (int i = 0; i < MAX_PLATEAUS; i++) begin
            hit_next[i] = (4'(i) < count_eff)
                       && (plateaus_reg[i*PLATEAU_W +: PLATEAU_W] < totlen1_reg);
        end
    end

    logic [7:0]              t6_2_reg, c6_2_reg;
    logic [31:0]             r6_2_reg;
    logic                    drop2_reg, is_mtu2_reg;
    logic [MAX_PLATEAUS-1:0] hit2_reg;
    logic [15:0]             pkt_mtu2_reg;
    logic [27:0]             mtu6_2_reg, mtu4_2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            t6_2_reg     <= t6_next;
            c6_2_reg     <= c6_next;
            r6_2_reg     <= r6_next;
            drop2_reg    <= drop_next;
            is_mtu2_reg  <= is_mtu_next;
            hit2_reg     <= hit_next;
            pkt_mtu2_reg <= rest1_reg[15:0];
            mtu6_2_reg   <= mtu6_1_reg;
            mtu4_2_reg   <= mtu4_1_reg;
        end
    end

    // ---------------- stage 3: plateau select and mtu adds ----------------
    logic [15:0] mtu_sel;
    logic [16:0] a_next;
    logic [28:0] b_next;

    always_comb begin
        mtu_sel = pkt_mtu2_reg;
        if (pkt_mtu2_reg == 16'd0) begin
            // walk down so the matching entry with the lowest index wins
            for (int i = MAX_PLATEAUS - 1; i >= 0; i--) begin
                if (hit2_reg[i]) begin
                    mtu_sel = plateaus_reg[i*PLATEAU_W +: PLATEAU_W];
                end
            end
        end
    end

    assign a_next = {1'b0, mtu_sel} + {1'b0, IPV4_HDR_DELTA};
    assign b_next = {1'b0, mtu4_2_reg} + {13'd0, IPV4_HDR_DELTA};

    logic [7:0]  t6_3_reg, c6_3_reg;
    logic [31:0] r6_3_reg;
    logic        drop3_reg, is_mtu3_reg;
    logic [16:0] a3_reg;
    logic [28:0] b3_reg;
    logic [27:0] mtu6_3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            t6_3_reg    <= t6_2_reg;
            c6_3_reg    <= c6_2_reg;
            r6_3_reg    <= r6_2_reg;
            drop3_reg   <= drop2_reg;
            is_mtu3_reg <= is_mtu2_reg;
            a3_reg      <= a_next;
            b3_reg      <= b_next;
            mtu6_3_reg  <= mtu6_2_reg;
        end
    end

    // ---------------- stage 4: minimum, clamp and result register ----------------
    logic [28:0] mtu_min;

    always_comb begin
        mtu_min = {1'b0, mtu6_3_reg};
        if (b3_reg < mtu_min) mtu_min = b3_reg;
        if ({12'd0, a3_reg} < mtu_min) mtu_min = {12'd0, a3_reg};
        // never report below the ipv6 minimum link mtu
        if (mtu_min < MIN_MTU6) mtu_min = MIN_MTU6;
    end

    logic [7:0]  t6_4_reg, c6_4_reg;
    logic [31:0] r6_4_reg;
    logic        drop4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            t6_4_reg  <= t6_3_reg;
            c6_4_reg  <= c6_3_reg;
            r6_4_reg  <= is_mtu3_reg ? {3'd0, mtu_min} : r6_3_reg;
            drop4_reg <= drop3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {r6_4_reg, c6_4_reg, t6_4_reg};
    assign m_tuser  = drop4_reg;

`ifndef SYNTH
    // a drop verdict carries an all-zero header
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 48'd0)
        else $error("drop result with nonzero header");

    // packet too big never reports an mtu below the ipv6 minimum
    a_ptb_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && m_tdata[7:0] == ICMP6_PKT_TOO_BIG
        |-> m_tdata[47:16] >= {3'd0, MIN_MTU6})
        else $error("packet too big mtu below minimum");

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted request lost at capture");

    // with every stage full and the output stalled, no request is taken
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && v4_reg && !m_tready |-> !s_tready)
        else $error("request accepted into a full pipeline");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// self-checking testbench for icmp4_to_icmp6_header_translate: random and directed headers
// against an in-bench translation predictor; depends on icmp46_pkg and the translator rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import icmp46_pkg::*;

    localparam int MAX_PLATEAUS = 12;
    // cycles without any request, result or configuration handshake before the run is declared hung
    localparam int HANG_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 235;

    // input request, declared msb first so that it maps straight onto s_tdata
    typedef struct packed {
        logic [15:0] nat64_icmp_id;
        logic [27:0] ipv4_link_mtu;
        logic [27:0] ipv6_link_mtu;
        logic [15:0] inner_total_length;
        logic [31:0] icmp4_rest;
        logic [7:0]  icmp4_code;
        logic [7:0]  icmp4_type;
    } icmp4_req_t;

    // translated header plus drop verdict
    typedef struct packed {
        logic        drop;
        logic [31:0] icmp6_rest;
        logic [7:0]  v6_code;
        logic [7:0]  v6_type;
    } icmp6_res_t;

    // ipv4 header offset to ipv6 header offset for parameter problem pointers
    localparam logic [7:0] PTR6_TABLE [20] = '{
        8'd0, 8'd1, 8'd4, 8'd4,
        PTR_NONE, PTR_NONE, PTR_NONE, PTR_NONE,
        8'd7, 8'd6, PTR_NONE, PTR_NONE,
        8'd8, 8'd8, 8'd8, 8'd8,
        8'd24, 8'd24, 8'd24, 8'd24
    };

    // the usual mtu plateau list, largest first
    localparam logic [15:0] STD_PLATEAUS [12] = '{
        16'd65535, 16'd32000, 16'd17914, 16'd8166, 16'd4352, 16'd2002,
        16'd1492, 16'd1006, 16'd508, 16'd296, 16'd68, 16'd0
    };

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = CFG_NAT64_MODE;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // lsb up: icmp4_type, icmp4_code, icmp4_rest, inner_total_length,
    // ipv6_link_mtu, ipv4_link_mtu, nat64_icmp_id
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // lsb up: v6_type, v6_code, icmp6_rest
    logic [47:0]  m_tdata;
    // drop
    logic [0:0]   m_tuser;

    // bench copy of the configuration registers
    logic         model_nat64 = 1'b0;
    logic [3:0]   model_count = '0;
    logic [191:0] model_plateaus = '0;

    icmp4_req_t icmp4_pending [$];   // requests waiting to be driven
    icmp6_res_t icmp6_expected [$];  // translations of accepted requests, oldest first
    icmp4_req_t req_on_bus;
    int         mismatch_count = 0;
    int         src_gap = 0;
    int         sink_hold = 0;
    bit         src_idle_on = 1'b1;
    bit         sink_idle_on = 1'b1;
    int         quiet_cycles = 0;

    icmp4_to_icmp6_header_translate #(
        .MAX_PLATEAUS(MAX_PLATEAUS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    // packet-too-big mtu: reported mtu, or the first plateau under the inner
    // length when none was reported, then min against both links and the 1280 floor
    function automatic logic [31:0] too_big_mtu(icmp4_req_t q);
        logic [15:0] pkt_mtu;
        logic [28:0] via_pkt, via_v4, best;
        int          lim;
        bit          found;
        pkt_mtu = q.icmp4_rest[15:0];
        lim = (model_count > MAX_PLATEAUS) ? MAX_PLATEAUS : int'(model_count);
        found = 1'b0;
        if (pkt_mtu == 16'd0) begin
            for (int i = 0; i < lim; i++) begin
                if (!found && model_plateaus[i*16 +: 16] < q.inner_total_length) begin
                    pkt_mtu = model_plateaus[i*16 +: 16];
                    found = 1'b1;
                end
            end
        end
        via_pkt = 29'(pkt_mtu) + 29'(IPV4_HDR_DELTA);
        via_v4 = 29'(q.ipv4_link_mtu) + 29'(IPV4_HDR_DELTA);
        best = 29'(q.ipv6_link_mtu);
        if (via_v4 < best) best = via_v4;
        if (via_pkt < best) best = via_pkt;
        if (best < MIN_MTU6) best = MIN_MTU6;
        return 32'(best);
    endfunction

    function automatic icmp6_res_t translate_header(icmp4_req_t q);
        icmp6_res_t r;
        logic [7:0] ptr4, ptr6;
        r = '0;
        case (q.icmp4_type)
            ICMP4_ECHO_REQUEST, ICMP4_ECHO_REPLY: begin
                r.v6_type = (q.icmp4_type == ICMP4_ECHO_REQUEST) ? ICMP6_ECHO_REQUEST
                                                                 : ICMP6_ECHO_REPLY;
                r.v6_code = C6_ZERO;
                // nat64 swaps in the translated identifier, sequence always kept
                r.icmp6_rest = model_nat64 ? {q.nat64_icmp_id, q.icmp4_rest[15:0]}
                                           : q.icmp4_rest;
            end
            ICMP4_DEST_UNREACH: begin
                r.v6_type = ICMP6_DEST_UNREACH;
                case (q.icmp4_code)
                    UNR_NET, UNR_HOST, UNR_SRC_ROUTE, UNR_NET_UNKNOWN, UNR_HOST_UNKNOWN,
                    UNR_HOST_ISOLATED, UNR_NET_TOS, UNR_HOST_TOS: begin
                        r.v6_code = C6_NO_ROUTE;
                    end
                    UNR_PROTO: begin
                        r.v6_type = ICMP6_PARAM_PROBLEM;
                        r.v6_code = C6_UNRECOG_NH;
                        r.icmp6_rest = PTR6_NEXT_HEADER;
                    end
                    UNR_PORT: begin
                        r.v6_code = C6_PORT_UNREACH;
                    end
                    UNR_FRAG_NEEDED: begin
                        r.v6_type = ICMP6_PKT_TOO_BIG;
                        r.v6_code = C6_ZERO;
                        r.icmp6_rest = too_big_mtu(q);
                    end
                    UNR_NET_PROHIB, UNR_HOST_PROHIB, UNR_ADMIN_PROHIB, UNR_PREC_CUTOFF: begin
                        r.v6_code = C6_ADMIN_PROHIB;
                    end
                    default: r.drop = 1'b1;
                endcase
            end
            ICMP4_TIME_EXCEEDED: begin
                r.v6_type = ICMP6_TIME_EXCEEDED;
                r.v6_code = q.icmp4_code;
            end
            ICMP4_PARAM_PROBLEM: begin
                if (q.icmp4_code == PP4_POINTER || q.icmp4_code == PP4_BAD_LENGTH) begin
                    ptr4 = q.icmp4_rest[31:24];
                    ptr6 = (ptr4 < PTR_MAP_LEN) ? PTR6_TABLE[ptr4[4:0]] : PTR_NONE;
                    if (ptr6 == PTR_NONE) begin
                        r.drop = 1'b1;
                    end else begin
                        r.v6_type = ICMP6_PARAM_PROBLEM;
                        r.v6_code = C6_ERR_HEADER;
                        r.icmp6_rest = 32'(ptr6);
                    end
                end else begin
                    r.drop = 1'b1;
                end
            end
            default: r.drop = 1'b1;
        endcase
        // a dropped header carries nothing else
        if (r.drop) begin
            r = '0;
            r.drop = 1'b1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic icmp4_req_t make_req(logic [7:0] t4, logic [7:0] c4, logic [31:0] rest,
                                            logic [15:0] tot, logic [27:0] mtu6,
                                            logic [27:0] mtu4, logic [15:0] id6);
        icmp4_req_t q;
        q.icmp4_type = t4;
        q.icmp4_code = c4;
        q.icmp4_rest = rest;
        q.inner_total_length = tot;
        q.ipv6_link_mtu = mtu6;
        q.ipv4_link_mtu = mtu4;
        q.nat64_icmp_id = id6;
        return q;
    endfunction

    // link mtus: mostly realistic, some full range and the hairpin marker
    function automatic logic [27:0] random_link_mtu();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 28'($urandom());
        if (r < 50) return 28'($urandom_range(1000, 1600));
        if (r < 65) return 28'hfffffff;
        if (r < 80) return 28'($urandom_range(0, 1400));
        return 28'($urandom_range(1260, 9000));
    endfunction

    function automatic icmp4_req_t random_req();
        icmp4_req_t q;
        int r;
        q = make_req(8'($urandom()), 8'($urandom()), $urandom(), 16'($urandom()),
                     random_link_mtu(), random_link_mtu(), 16'($urandom()));
        if ($urandom_range(0, 1) == 0) q.inner_total_length = 16'($urandom_range(0, 1600));
        r = $urandom_range(0, 99);
        if (r < 18) begin
            q.icmp4_type = ICMP4_ECHO_REQUEST;
        end else if (r < 30) begin
            q.icmp4_type = ICMP4_ECHO_REPLY;
        end else if (r < 60) begin
            q.icmp4_type = ICMP4_DEST_UNREACH;
            if ($urandom_range(0, 99) < 35) q.icmp4_code = UNR_FRAG_NEEDED;
            else if ($urandom_range(0, 99) < 85) q.icmp4_code = 8'($urandom_range(0, 15));
            // frag needed: often no reported mtu so the plateaus decide
            r = $urandom_range(0, 99);
            if (r < 50) q.icmp4_rest[15:0] = 16'd0;
            else if (r < 75) q.icmp4_rest[15:0] = 16'($urandom_range(0, 1400));
        end else if (r < 70) begin
            q.icmp4_type = ICMP4_TIME_EXCEEDED;
        end else if (r < 88) begin
            q.icmp4_type = ICMP4_PARAM_PROBLEM;
            r = $urandom_range(0, 99);
            if (r < 40) q.icmp4_code = PP4_POINTER;
            else if (r < 80) q.icmp4_code = PP4_BAD_LENGTH;
            if ($urandom_range(0, 99) < 80) q.icmp4_rest[31:24] = 8'($urandom_range(0, 19));
        end
        return q;
    endfunction

    function automatic logic [191:0] random_plateaus();
        logic [191:0] bank;
        for (int i = 0; i < 12; i++) begin
            if ($urandom_range(0, 1) == 0) bank[i*16 +: 16] = 16'($urandom());
            else bank[i*16 +: 16] = STD_PLATEAUS[4'($urandom_range(0, 11))];
        end
        return bank;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------- configuration

    // one register write; leaves cfg_valid high so writes can go back to back
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_NAT64_MODE:      model_nat64 = value[0];
            CFG_PLATEAU_COUNT:   model_count = value[3:0];
            CFG_PLATEAUS_FIRST:  model_plateaus[63:0] = value;
            CFG_PLATEAUS_MIDDLE: model_plateaus[127:64] = value;
            CFG_PLATEAUS_LAST:   model_plateaus[191:128] = value;
            default: ;
        endcase
    endtask

    // rewrites every register; unused upper bits of the narrow ones get noise
    task automatic program_regs(input logic nat64, input logic [3:0] count,
                                input logic [191:0] bank);
        logic [63:0] v;
        @(posedge aclk);
        v = {$urandom(), $urandom()};
        v[0] = nat64;
        write_reg(CFG_NAT64_MODE, v);
        v = {$urandom(), $urandom()};
        v[3:0] = count;
        write_reg(CFG_PLATEAU_COUNT, v);
        write_reg(CFG_PLATEAUS_FIRST, bank[63:0]);
        write_reg(CFG_PLATEAUS_MIDDLE, bank[127:64]);
        write_reg(CFG_PLATEAUS_LAST, bank[191:128]);
        cfg_valid <= 1'b0;
    endtask

    // checked at the falling edge so the driver's updates for the edge have landed
    task automatic wait_drained();
        do @(negedge aclk);
        while (icmp4_pending.size() != 0 || s_tvalid || icmp6_expected.size() != 0);
    endtask

    // ---------------------------------------------------------------- request driver

    // the held request is predicted when it is accepted; a new one goes out after
    // its gap, and valid gets exactly one assignment per edge
    always @(posedge aclk) begin : request_driver
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                icmp6_expected.push_back(translate_header(req_on_bus));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (icmp4_pending.size() != 0) begin
                    req_on_bus = icmp4_pending.pop_front();
                    s_tdata <= req_on_bus;
                    next_valid = 1'b1;
                    // switch between idling and back-to-back stretches now and then
                    if ($urandom_range(0, 63) == 0) src_idle_on = !src_idle_on;
                    src_gap = pick_gap(src_idle_on);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ---------------------------------------------------------------- result monitor

    always @(posedge aclk) begin : result_monitor
        icmp6_res_t got, want;
        logic next_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.drop = m_tuser[0];
                got.v6_type = m_tdata[7:0];
                got.v6_code = m_tdata[15:8];
                got.icmp6_rest = m_tdata[47:16];
                if (icmp6_expected.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: %h", got));
                end else begin
                    want = icmp6_expected.pop_front();
                    if (got.drop !== want.drop)
                        report_mismatch($sformatf("drop %b, want %b", got.drop, want.drop));
                    if (got.v6_type !== want.v6_type)
                        report_mismatch($sformatf("v6_type %0d, want %0d",
                                                  got.v6_type, want.v6_type));
                    if (got.v6_code !== want.v6_code)
                        report_mismatch($sformatf("v6_code %0d, want %0d",
                                                  got.v6_code, want.v6_code));
                    if (got.icmp6_rest !== want.icmp6_rest)
                        report_mismatch($sformatf("icmp6_rest %h, want %h",
                                                  got.icmp6_rest, want.icmp6_rest));
                end
                if ($urandom_range(0, 63) == 0) sink_idle_on = !sink_idle_on;
            end
            // backpressure: ready stays low for a random stretch, then opens again
            if (sink_hold > 0) begin
                sink_hold--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
                if ($urandom_range(0, 99) < 30) sink_hold = pick_gap(sink_idle_on);
            end
            m_tready <= next_ready;
        end
    end

    // ---------------------------------------------------------------- hang watchdog

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : run_sequence
        logic [191:0] std_bank;
        logic         nat64;
        logic [3:0]   count;
        logic [191:0] bank;
        for (int i = 0; i < 12; i++) std_bank[i*16 +: 16] = STD_PLATEAUS[i];

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // a few random headers on the reset configuration
        for (int i = 0; i < 40; i++) icmp4_pending.push_back(random_req());
        wait_drained();

        // directed: nat64 mode with the full standard plateau list
        program_regs(1'b1, 4'd12, std_bank);
        icmp4_pending.push_back(make_req(ICMP4_ECHO_REQUEST, 8'd0, 32'h12345678, 16'd0,
                                         28'd0, 28'd0, 16'hffff));
        icmp4_pending.push_back(make_req(ICMP4_ECHO_REPLY, 8'hff, 32'hffffffff, 16'hffff,
                                         28'hfffffff, 28'hfffffff, 16'h0000));
        // every unreachable code; frag needed picks the 8166 plateau here
        for (int c = 0; c < 16; c++)
            icmp4_pending.push_back(make_req(ICMP4_DEST_UNREACH, 8'(c), 32'h0, 16'd9000,
                                             28'hfffffff, 28'hfffffff, 16'h1234));
        // frag needed with the largest reported mtu
        icmp4_pending.push_back(make_req(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'h0000ffff,
                                         16'd1500, 28'hfffffff, 28'hfffffff, 16'h0));
        // no plateau below a zero inner length, zero links: clamps to the minimum
        icmp4_pending.push_back(make_req(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'h0,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        // ipv4 link decides the minimum
        icmp4_pending.push_back(make_req(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'hffff05dc,
                                         16'd1500, 28'd1400, 28'd1300, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_TIME_EXCEEDED, 8'd0, 32'hffffffff, 16'd0,
                                         28'd0, 28'd0, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_TIME_EXCEEDED, 8'hff, 32'h0, 16'd0,
                                         28'd0, 28'd0, 16'h0));
        // parameter problem: first and last mapped pointers, bad length, unmapped, out of table, bad code
        icmp4_pending.push_back(make_req(ICMP4_PARAM_PROBLEM, PP4_POINTER, 32'h00ffffff,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_PARAM_PROBLEM, PP4_POINTER, 32'h13000000,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_PARAM_PROBLEM, PP4_BAD_LENGTH, 32'h09000000,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_PARAM_PROBLEM, PP4_POINTER, 32'h04000000,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_PARAM_PROBLEM, PP4_POINTER, 32'hff000000,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        icmp4_pending.push_back(make_req(ICMP4_PARAM_PROBLEM, 8'd1, 32'h00000000,
                                         16'd0, 28'd0, 28'd0, 16'h0));
        // unknown type
        icmp4_pending.push_back(make_req(8'hff, 8'd0, 32'h0, 16'd0, 28'd0, 28'd0, 16'h0));
        wait_drained();

        // random phases, each on its own register setting; the first three are set by hand
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    // count above the table saturates; all plateaus at maximum
                    nat64 = 1'b0;
                    count = 4'd15;
                    bank = '1;
                end
                1: begin
                    nat64 = 1'b1;
                    count = 4'd0;
                    bank = '0;
                end
                2: begin
                    nat64 = 1'b1;
                    count = 4'd12;
                    bank = std_bank;
                end
                default: begin
                    nat64 = 1'($urandom_range(0, 1));
                    count = 4'($urandom_range(0, 15));
                    bank = random_plateaus();
                end
            endcase
            program_regs(nat64, count, bank);
            for (int i = 0; i < PHASE_ITEMS; i++) icmp4_pending.push_back(random_req());
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
